// ===== rtl/bps_pkg.sv =====
// Shared types, operation codes and the default pattern table of the beep pattern sequencer.
package bps_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_ACTIVATE   = 3'd1;
    localparam logic [2:0] MODE_DEACTIVATE = 3'd2;
    localparam logic [2:0] MODE_DEACT_ALL  = 3'd3;
    localparam logic [2:0] MODE_LOAD       = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONTINUOUS = 2'd0;
    localparam logic [1:0] CFG_PAUSE      = 2'd1;

    // Tone generator register values.
    localparam logic [4:0] LOW_DIVIDER    = 5'd20;
    localparam logic [4:0] HIGH_DIVIDER   = 5'd4;
    localparam logic [8:0] LOW_GRADE      = 9'h09;
    localparam logic [8:0] HIGH_COUNT     = 9'h63;
    localparam logic [7:0] PAUSE_RESET    = 8'd6;

    // One stored pattern; the packed layout matches the 27-bit store word.
    typedef struct packed {
        logic       tone;
        logic [4:0] off_second;
        logic [4:0] on_second;
        logic [4:0] off_first;
        logic [4:0] on_first;
        logic [2:0] steps;
        logic [2:0] repeats;
    } pattern_t;

    // Per-slot progress kept in the slot state memory.
    typedef struct packed {
        logic [3:0] repeat_count;
        logic [2:0] step;
    } slot_state_t;

    // Register writes and start pulse produced by one item.
    typedef struct packed {
        logic       write_frequency;
        logic [4:0] frequency_divider;
        logic       write_shape;
        logic [8:0] decrement_grade;
        logic [8:0] tone_count;
        logic       start_tone;
    } result_t;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_EXEC     = 4'b0100,
        ST_FINISH   = 4'b1000
    } fsm_t;

    localparam slot_state_t SLOT_STATE_RESET = '{repeat_count: 4'd1, step: 3'd1};

    // Built-in patterns; slots from eight upward hold all zero.
    function automatic pattern_t default_pattern(input logic [3:0] slot);
        pattern_t p;
        p = '0;
        case (slot)
            4'd0: p = '{1'b0, 5'd0, 5'd0, 5'd2, 5'd2, 3'd2, 3'd5};
            4'd1: p = '{1'b1, 5'd0, 5'd0, 5'd0, 5'd20, 3'd1, 3'd1};
            4'd2: p = '{1'b1, 5'd0, 5'd0, 5'd0, 5'd20, 3'd1, 3'd1};
            4'd3: p = '{1'b0, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd4};
            4'd4: p = '{1'b1, 5'd0, 5'd0, 5'd2, 5'd2, 3'd2, 3'd5};
            4'd5: p = '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd1};
            4'd6: p = '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd4};
            4'd7: p = '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd6};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/bps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/beep_pattern_sequencer.sv =====
// Top level of the beep pattern sequencer: command decode, slot scan and pattern stepping.
//
//  Channel  Signals                              Direction  Content
//  s        s_tvalid s_tready s_tdata s_tuser    in         one operation per item
//  m        m_tvalid m_tready m_tdata            out        one result item per input item
//  cfg      cfg_valid cfg_ready cfg_index cfg_data in       register writes, always ready
//
// A tick that finds an active sound passes through these steps: the accepting idle state,
// decode and slot scan with both memory reads issued, the update and write back on the
// read data, then the hand-off to the result register. Every other item skips the
// update step. Reset clears all activity flags and memory valid bits at once, so the
// block is ready right after reset. A stalled result holds the next item in its final
// step; the input side takes no new item until that result has moved to the output.
module beep_pattern_sequencer #(
    parameter int NUM_SOUNDS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] sound_index, [3] generator_busy, [6:4] pattern_repeats, [9:7] pattern_steps,
    // [14:10] on_time_first, [19:15] off_time_first, [24:20] on_time_second,
    // [29:25] off_time_second, [30] pattern_tone, [31] zero
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,   // [2:0] mode
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] write_frequency, [5:1] frequency_divider, [6] write_shape,
    // [15:7] decrement_grade, [24:16] tone_count, [25] start_tone,
    // [28:26] playing_sound, [31:29] zero
    output logic [31:0] m_tdata,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import bps_pkg::*;

    localparam int SLOT_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;

    // Configuration registers.
    logic [2:0] continuous_reg;
    logic [7:0] pause_ticks_reg;

    // Control state.
    fsm_t                  state_reg, state_next;
    logic [NUM_SOUNDS-1:0] active_reg, active_next;
    logic [NUM_SOUNDS-1:0] latched_reg, latched_next;
    logic [NUM_SOUNDS-1:0] pat_valid_reg, pat_valid_next;
    logic [NUM_SOUNDS-1:0] st_valid_reg, st_valid_next;
    logic [7:0]            pause_reg, pause_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [5:0]            countdown_reg, countdown_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // Item and result payload.
    logic [2:0]  mode_reg;
    logic [2:0]  idx_reg;
    logic        busy_reg;
    pattern_t    ld_pat_reg;
    result_t     res_reg, res_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic              pram_we;
    pattern_t          pram_rdata;
    logic              sram_we;
    slot_state_t       sram_wdata;
    slot_state_t       sram_rdata;
    logic [SLOT_W-1:0] scan_slot;
    logic              scan_found;

    // Derived item values.
    logic              idx_ok;
    logic [SLOT_W-1:0] idx_slot;
    pattern_t          cur_pat;
    slot_state_t       cur_st;
    logic              expired;
    logic [5:0]        countdown_dec;
    logic [SLOT_W:0]   slot_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Register values for one tone step.
    function automatic result_t emit_tone(input logic [4:0] t, input logic tone,
                                          input logic with_freq, input logic busy);
        result_t r;
        logic [8:0] t9;
        t9 = {4'b0, t};
        r = '0;
        if (tone)
        begin
            r.frequency_divider = HIGH_DIVIDER;
            r.decrement_grade   = (t != 5'd0) ? ((t9 << 3) + (t9 << 1) - 9'd1) : 9'd0;
            r.tone_count        = HIGH_COUNT;
        end
        else
        begin
            r.frequency_divider = LOW_DIVIDER;
            r.decrement_grade   = LOW_GRADE;
            r.tone_count        = (t != 5'd0) ? ((t9 << 4) - 9'd1) : 9'd0;
        end
        r.write_frequency = with_freq;
        if (!with_freq)
        begin
            r.frequency_divider = '0;
        end
        r.write_shape = 1'b1;
        r.start_tone  = !busy;
        return r;
    endfunction

    // Stored patterns.
    bps_ram #(
        .WIDTH ($bits(pattern_t)),
        .DEPTH (NUM_SOUNDS)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pram_we),
        .waddr (idx_slot),
        .wdata (ld_pat_reg),
        .raddr (scan_slot),
        .rdata (pram_rdata)
    );

    // Repeat count and step number of each slot.
    bps_ram #(
        .WIDTH ($bits(slot_state_t)),
        .DEPTH (NUM_SOUNDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (cur_reg),
        .wdata (sram_wdata),
        .raddr (scan_slot),
        .rdata (sram_rdata)
    );

    // Lowest active slot at or above the current slot.
    always_comb
    begin
        scan_found = 1'b0;
        scan_slot  = '0;
        for (int i = NUM_SOUNDS - 1; i >= 0; i--)
        begin
            if (active_reg[i] && (SLOT_W'(i) >= cur_reg))
            begin
                scan_found = 1'b1;
                scan_slot  = SLOT_W'(i);
            end
        end
    end

    // Item slot decode and memory read data with reset defaults.
    assign idx_ok   = ({2'b0, idx_reg} < 5'(NUM_SOUNDS));
    assign idx_slot = SLOT_W'(idx_reg);
    assign cur_pat  = pat_valid_reg[cur_reg] ? pram_rdata : default_pattern(4'(cur_reg));
    assign cur_st   = st_valid_reg[cur_reg] ? sram_rdata : SLOT_STATE_RESET;

    // A countdown of zero or one ends the step.
    assign expired       = (countdown_reg <= 6'd1);
    assign countdown_dec = expired ? 6'd0 : (countdown_reg - 6'd1);
    assign slot_inc      = {1'b0, cur_reg} + {{SLOT_W{1'b0}}, 1'b1};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        latched_next   = latched_reg;
        pat_valid_next = pat_valid_reg;
        st_valid_next  = st_valid_reg;
        pause_next     = pause_reg;
        cur_next       = cur_reg;
        countdown_next = countdown_reg;
        res_next       = res_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        pram_we        = 1'b0;
        sram_we        = 1'b0;
        sram_wdata     = cur_st;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DISPATCH;
                end
            end

            // Decode the operation; a tick with an active sound goes on to read memory.
            ST_DISPATCH:
            begin
                res_next   = '0;
                state_next = ST_FINISH;
                case (mode_reg)
                    MODE_TICK:
                    begin
                        if (pause_reg != 8'd0)
                        begin
                            pause_next = pause_reg - 8'd1;
                        end
                        else if (scan_found)
                        begin
                            cur_next   = scan_slot;
                            state_next = ST_EXEC;
                        end
                        else
                        begin
                            cur_next = '0;
                        end
                    end
                    MODE_ACTIVATE:
                    begin
                        if (idx_ok && !latched_reg[idx_slot])
                        begin
                            active_next[idx_slot]  = 1'b1;
                            latched_next[idx_slot] = 1'b1;
                        end
                    end
                    MODE_DEACTIVATE:
                    begin
                        if (idx_ok)
                        begin
                            active_next[idx_slot]   = 1'b0;
                            latched_next[idx_slot]  = 1'b0;
                            st_valid_next[idx_slot] = 1'b0;
                        end
                    end
                    MODE_DEACT_ALL:
                    begin
                        active_next          = '0;
                        latched_next         = '0;
                        st_valid_next        = '0;
                        res_next.write_shape = 1'b1;
                    end
                    MODE_LOAD:
                    begin
                        if (idx_ok)
                        begin
                            pram_we                  = 1'b1;
                            pat_valid_next[idx_slot] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Step the pattern of the current slot and write its state back.
            ST_EXEC:
            begin
                state_next    = ST_FINISH;
                sram_we       = 1'b1;
                st_valid_next[cur_reg] = 1'b1;
                if (cur_st.repeat_count <= {1'b0, cur_pat.repeats})
                begin
                    case (cur_st.step)
                        3'd1:
                        begin
                            res_next = emit_tone(cur_pat.on_first, cur_pat.tone, 1'b1, busy_reg);
                            sram_wdata.step = 3'd2;
                            countdown_next  = {1'b0, cur_pat.on_first}
                                            + {1'b0, cur_pat.off_first};
                        end
                        3'd2:
                        begin
                            countdown_next = countdown_dec;
                            if (expired)
                            begin
                                if (cur_pat.steps == 3'd1 || cur_pat.steps == 3'd2)
                                begin
                                    sram_wdata.step         = 3'd1;
                                    sram_wdata.repeat_count = cur_st.repeat_count + 4'd1;
                                end
                                else
                                begin
                                    sram_wdata.step = 3'd3;
                                end
                            end
                        end
                        3'd3:
                        begin
                            res_next = emit_tone(cur_pat.on_second, cur_pat.tone, 1'b0,
                                                 busy_reg);
                            sram_wdata.step = 3'd4;
                            countdown_next  = {1'b0, cur_pat.on_second}
                                            + {1'b0, cur_pat.off_second};
                        end
                        3'd4:
                        begin
                            countdown_next = countdown_dec;
                            if (expired)
                            begin
                                sram_wdata.step = 3'd1;
                                if ({1'b0, continuous_reg} == 4'(cur_reg))
                                begin
                                    sram_wdata.repeat_count = 4'd1;
                                end
                                else
                                begin
                                    sram_wdata.repeat_count = cur_st.repeat_count + 4'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    // Repeats done: retire the sound and start the pause.
                    sram_wdata.repeat_count = 4'd1;
                    active_next[cur_reg]    = 1'b0;
                    pause_next              = pause_ticks_reg;
                    if (slot_inc >= (SLOT_W + 1)'(NUM_SOUNDS))
                    begin
                        cur_next = '0;
                    end
                    else
                    begin
                        cur_next = slot_inc[SLOT_W-1:0];
                    end
                end
            end

            // Hand the result to the output register once it is free.
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {3'b0, 3'(cur_reg), res_reg.start_tone, res_reg.tone_count,
                                     res_reg.decrement_grade, res_reg.write_shape,
                                     res_reg.frequency_divider, res_reg.write_frequency};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            latched_reg   <= '0;
            pat_valid_reg <= '0;
            st_valid_reg  <= '0;
            pause_reg     <= '0;
            cur_reg       <= '0;
            countdown_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            latched_reg   <= latched_next;
            pat_valid_reg <= pat_valid_next;
            st_valid_reg  <= st_valid_next;
            pause_reg     <= pause_next;
            cur_reg       <= cur_next;
            countdown_reg <= countdown_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            continuous_reg  <= '0;
            pause_ticks_reg <= PAUSE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONTINUOUS: continuous_reg  <= cfg_data[2:0];
                CFG_PAUSE:      pause_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Item capture and result payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg   <= s_tuser;
            idx_reg    <= s_tdata[2:0];
            busy_reg   <= s_tdata[3];
            ld_pat_reg <= '{tone:       s_tdata[30],
                            off_second: s_tdata[29:25],
                            on_second:  s_tdata[24:20],
                            off_first:  s_tdata[19:15],
                            on_first:   s_tdata[14:10],
                            steps:      s_tdata[9:7],
                            repeats:    s_tdata[6:4]};
        end
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== dv/bps_checker.sv =====
// Checker for the beep pattern sequencer: predicts every result item and compares it.
module bps_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int SOUND_SLOTS = 8;

    // Progress through one pattern: tone, silence, second tone, second silence.
    localparam logic [2:0] STEP_FIRST_ON   = 3'd1;
    localparam logic [2:0] STEP_FIRST_OFF  = 3'd2;
    localparam logic [2:0] STEP_SECOND_ON  = 3'd3;
    localparam logic [2:0] STEP_SECOND_OFF = 3'd4;

    // Patterns held in the store right after reset.
    localparam pattern_t FACTORY_TABLE [0:7] = '{
        '{1'b0, 5'd0, 5'd0, 5'd2, 5'd2, 3'd2, 3'd5},
        '{1'b1, 5'd0, 5'd0, 5'd0, 5'd20, 3'd1, 3'd1},
        '{1'b1, 5'd0, 5'd0, 5'd0, 5'd20, 3'd1, 3'd1},
        '{1'b0, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd4},
        '{1'b1, 5'd0, 5'd0, 5'd2, 5'd2, 3'd2, 3'd5},
        '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd1},
        '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd4},
        '{1'b1, 5'd1, 5'd1, 5'd1, 5'd2, 3'd4, 3'd6}
    };

    // One result item as it leaves on m_tdata.
    typedef struct packed {
        logic       write_frequency;
        logic [4:0] frequency_divider;
        logic       write_shape;
        logic [8:0] decrement_grade;
        logic [8:0] tone_count;
        logic       start_tone;
        logic [2:0] playing_sound;
    } beep_result_t;

    // Predicted sequencer state and configuration.
    pattern_t     patterns    [SOUND_SLOTS];
    logic         sound_on    [SOUND_SLOTS];
    logic         armed       [SOUND_SLOTS];
    logic [3:0]   repeat_no   [SOUND_SLOTS];
    logic [2:0]   step_no     [SOUND_SLOTS];
    logic [7:0]   pause_left;
    logic [2:0]   slot_ptr;
    logic [5:0]   step_timer;
    logic [2:0]   continuous_slot;
    logic [7:0]   pause_setting;

    beep_result_t pending_results[$];
    int           fail_count = 0;

    assign mismatches = fail_count;

    // Register values for one tone; only the first tone of a pattern sets the divider.
    function automatic beep_result_t tone_writes(input logic [4:0] ticks, input logic high,
                                                 input logic with_freq, input logic busy);
        beep_result_t r;
        r = '0;
        if (high)
        begin
            r.frequency_divider = HIGH_DIVIDER;
            r.decrement_grade   = (ticks == 5'd0) ? 9'd0 : {4'd0, ticks} * 9'd10 - 9'd1;
            r.tone_count        = HIGH_COUNT;
        end
        else
        begin
            r.frequency_divider = LOW_DIVIDER;
            r.decrement_grade   = LOW_GRADE;
            r.tone_count        = (ticks == 5'd0) ? 9'd0 : {4'd0, ticks} * 9'd16 - 9'd1;
        end
        r.write_frequency = with_freq;
        if (!with_freq)
            r.frequency_divider = '0;
        r.write_shape = 1'b1;
        r.start_tone  = !busy;
        return r;
    endfunction

    // A step timer of zero or one runs out on this tick.
    function automatic logic step_timer_expired();
        if (step_timer <= 6'd1)
        begin
            step_timer = '0;
            return 1'b1;
        end
        step_timer = step_timer - 6'd1;
        return 1'b0;
    endfunction

    function automatic void clear_slot(input logic [2:0] slot);
        sound_on[slot]  = 1'b0;
        armed[slot]     = 1'b0;
        repeat_no[slot] = 4'd1;
        step_no[slot]   = STEP_FIRST_ON;
    endfunction

    // A tick: run down the pause, else step the lowest active sound from the pointer up.
    function automatic beep_result_t tick_response(input logic busy);
        beep_result_t r;
        pattern_t     pat;
        logic [2:0]   s;
        logic         found;
        r = '0;
        found = 1'b0;
        if (pause_left != 8'd0)
        begin
            pause_left = pause_left - 8'd1;
            return r;
        end
        for (int i = int'(slot_ptr); i < SOUND_SLOTS; i++)
        begin
            if (!found && sound_on[i])
            begin
                slot_ptr = 3'(i);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            slot_ptr = '0;
            return r;
        end
        s = slot_ptr;
        pat = patterns[s];
        if (repeat_no[s] <= {1'b0, pat.repeats})
        begin
            case (step_no[s])
                STEP_FIRST_ON:
                begin
                    r = tone_writes(pat.on_first, pat.tone, 1'b1, busy);
                    step_no[s] = STEP_FIRST_OFF;
                    step_timer = {1'b0, pat.on_first} + {1'b0, pat.off_first};
                end
                STEP_FIRST_OFF:
                begin
                    if (step_timer_expired())
                    begin
                        // One or two steps make a single tone/silence pair.
                        if (pat.steps == 3'd1 || pat.steps == 3'd2)
                        begin
                            step_no[s] = STEP_FIRST_ON;
                            repeat_no[s] = repeat_no[s] + 4'd1;
                        end
                        else
                            step_no[s] = STEP_SECOND_ON;
                    end
                end
                STEP_SECOND_ON:
                begin
                    r = tone_writes(pat.on_second, pat.tone, 1'b0, busy);
                    step_no[s] = STEP_SECOND_OFF;
                    step_timer = {1'b0, pat.on_second} + {1'b0, pat.off_second};
                end
                STEP_SECOND_OFF:
                begin
                    if (step_timer_expired())
                    begin
                        step_no[s] = STEP_FIRST_ON;
                        // The continuous sound starts over instead of counting.
                        if (s == continuous_slot)
                            repeat_no[s] = 4'd1;
                        else
                            repeat_no[s] = repeat_no[s] + 4'd1;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            // Repeats used up: retire the sound and hold silence before the next.
            repeat_no[s] = 4'd1;
            sound_on[s]  = 1'b0;
            slot_ptr     = s + 3'd1;
            pause_left   = pause_setting;
        end
        return r;
    endfunction

    // Expected result of one accepted input item.
    function automatic beep_result_t sequencer_response(input logic [2:0] op,
                                                        input logic [31:0] word);
        beep_result_t r;
        logic [2:0]   slot;
        slot = word[2:0];
        r = '0;
        case (op)
            MODE_TICK:
                r = tick_response(word[3]);
            MODE_ACTIVATE:
            begin
                if (!armed[slot])
                begin
                    sound_on[slot] = 1'b1;
                    armed[slot]    = 1'b1;
                end
            end
            MODE_DEACTIVATE:
                clear_slot(slot);
            MODE_DEACT_ALL:
            begin
                for (int i = 0; i < SOUND_SLOTS; i++)
                    clear_slot(3'(i));
                r.write_shape = 1'b1;
            end
            MODE_LOAD:
                patterns[slot] = pattern_t'(word[30:4]);
            default: ;
        endcase
        r.playing_sound = slot_ptr;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Watch all three channels on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        beep_result_t want;
        beep_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SOUND_SLOTS; i++)
            begin
                patterns[i] = FACTORY_TABLE[i];
                clear_slot(3'(i));
            end
            pause_left      = '0;
            slot_ptr        = '0;
            step_timer      = '0;
            continuous_slot = '0;
            pause_setting   = PAUSE_RESET;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Register writes; unknown indexes have no effect.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CONTINUOUS)
                    continuous_slot = cfg_data[2:0];
                else if (cfg_index == CFG_PAUSE)
                    pause_setting = cfg_data;
            end
            // Compare before queueing, so a result can never match its own input.
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[0], m_tdata[5:1], m_tdata[6], m_tdata[15:7],
                        m_tdata[24:16], m_tdata[25], m_tdata[28:26]};
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result item with nothing expected, tdata %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("write_frequency", 9'(want.write_frequency),
                                9'(got.write_frequency));
                    check_field("frequency_divider", 9'(want.frequency_divider),
                                9'(got.frequency_divider));
                    check_field("write_shape", 9'(want.write_shape), 9'(got.write_shape));
                    check_field("decrement_grade", want.decrement_grade, got.decrement_grade);
                    check_field("tone_count", want.tone_count, got.tone_count);
                    check_field("start_tone", 9'(want.start_tone), 9'(got.start_tone));
                    check_field("playing_sound", 9'(want.playing_sound),
                                9'(got.playing_sound));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(sequencer_response(s_tuser, s_tdata));
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the beep pattern sequencer: clock, reset, stimulus and verdict.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam real        CLK_PERIOD  = 4.0;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE      = 8;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [1:0] CFG_UNUSED     = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    logic        hold_req;

    always #(CLK_PERIOD / 2) clk = ~clk;

    beep_pattern_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bps_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Input word: bit 31 zero, then the pattern, generator busy and slot.
    function automatic logic [31:0] item_word(input logic [2:0] slot, input logic busy,
                                              input pattern_t pat);
        return {1'b0, pat, busy, slot};
    endfunction

    // Mostly short step times, so patterns finish within a phase.
    function automatic logic [4:0] step_ticks();
        if ($urandom_range(0, 9) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 3));
    endfunction

    function automatic pattern_t random_pattern();
        pattern_t p;
        p.repeats    = 3'($urandom_range(0, 7));
        p.steps      = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                   : 3'($urandom_range(1, 4));
        p.on_first   = step_ticks();
        p.off_first  = step_ticks();
        p.on_second  = step_ticks();
        p.off_second = step_ticks();
        p.tone       = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // Offer one item; bursts of random length are separated by random gaps.
    task automatic send_op(input logic [2:0] op, input logic [31:0] word);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic tick(input logic busy);
        send_op(MODE_TICK, item_word(3'($urandom_range(0, 7)), busy, random_pattern()));
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // The caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [2:0] continuous, input logic [7:0] pause);
        write_reg(CFG_CONTINUOUS, {5'($urandom_range(0, 31)), continuous});
        write_reg(CFG_PAUSE, pause);
        cfg_valid <= 1'b0;
    endtask

    // Field extremes, every operation and the corner cases, under reset settings.
    task automatic run_directed();
        send_op(MODE_LOAD, item_word(3'd7, 1'b0, '1));
        send_op(MODE_LOAD, item_word(3'd0, 1'b1, '0));
        send_op(MODE_ACTIVATE, item_word(3'd0, 1'b0, '0));
        // A second activate before any deactivate is ignored.
        send_op(MODE_ACTIVATE, item_word(3'd0, 1'b0, '1));
        // Slot 0 has no repeats, so it retires at once and the pause starts.
        tick(1'b0);
        repeat (6) tick(1'b1);
        // High tone with zero step times: the grade is zero, the countdown counts as one.
        send_op(MODE_LOAD, item_word(3'd1, 1'b0,
                '{1'b1, 5'd0, 5'd0, 5'd0, 5'd0, 3'd1, 3'd2}));
        send_op(MODE_ACTIVATE, item_word(3'd1, 1'b0, '0));
        tick(1'b1);
        tick(1'b0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        send_op(MODE_UNUSED_LO, item_word(3'd7, 1'b1, '1));
        send_op(MODE_UNUSED_LO + 3'd1, item_word(3'd0, 1'b0, '0));
        send_op(MODE_UNUSED_HI, item_word(3'd5, 1'b1, random_pattern()));
        send_op(MODE_DEACTIVATE, item_word(3'd1, 1'b0, '0));
        send_op(MODE_DEACT_ALL, item_word(3'd2, 1'b1, '0));
        send_op(MODE_ACTIVATE, item_word(3'd7, 1'b0, '0));
        tick(1'b0);
    endtask

    // Mostly ticks, with commands mixed in and a few unused operation codes.
    task automatic run_random(input int count);
        int          pick;
        logic [2:0]  op;
        logic [31:0] word;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            word = {1'b0, 31'($urandom())};
            word[3] = ($urandom_range(0, 3) == 0);
            if (pick < 60)
                op = MODE_TICK;
            else if (pick < 73)
                op = MODE_ACTIVATE;
            else if (pick < 82)
                op = MODE_DEACTIVATE;
            else if (pick < 84)
                op = MODE_DEACT_ALL;
            else if (pick < 96)
            begin
                op = MODE_LOAD;
                word = item_word(word[2:0], word[3], random_pattern());
            end
            else
                op = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            send_op(op, word);
        end
    endtask

    // Result side: changing stall patterns, plus one long hold when asked.
    initial
    begin : result_side
        int   style;
        int   span;
        logic held_once;
        held_once = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held_once)
            begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 2);
                span  = $urandom_range(8, 64);
                for (int k = 0; k < span; k++)
                begin
                    case (style)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= (k % 4 != 3);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Ends the run when no channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus phases, each under its own register settings.
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CONTINUOUS;
        cfg_data  <= '0;
        hold_req  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        // Continuous sound in the top slot, no pause.
        program_regs(3'd7, 8'd0);
        run_random(120);
        drain();

        // Longest pause; an unknown register index must change nothing.
        program_regs(3'd0, 8'd255);
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        run_random(60);
        drain();

        program_regs(3'($urandom_range(0, 7)), 8'($urandom_range(1, 12)));
        run_random(120);
        drain();

        // The result side holds off for a long stretch while items keep coming.
        program_regs(3'($urandom_range(0, 7)), 8'd2);
        hold_req <= 1'b1;
        run_random(200);
        drain();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bps_pkg.sv
rtl/bps_ram.sv
rtl/beep_pattern_sequencer.sv
dv/bps_checker.sv
dv/tb.sv
